// ===== design/apm_pkg.sv =====
package apm_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int GAIN_W     = 22;
    localparam int GAIN_FRAC  = 16;
    localparam int ACC_W      = 36;

    localparam int DIV_W      = ACC_W;
    localparam int DIV_STEP   = 4;
    localparam int DIV_ITER   = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_ITER);
    localparam int DEN_W      = 10;
    localparam logic [DEN_W-1:0] POW_DEN  = DEN_W'(1000);
    localparam logic [DIV_W-1:0] POW_HALF = DIV_W'(500);

    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = GAIN_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SPLIT      = 17;
    localparam int SUM_W      = 57;

    localparam int VOLT_W     = 16;
    localparam int AMP_IN_W   = 17;
    localparam int AMP_W      = 18;
    localparam int POW_W      = 24;

    localparam logic [DIV_W-1:0] VOLT_MAX     = DIV_W'((1 << VOLT_W) - 1);
    localparam logic [DIV_W-1:0] AMP_IN_MAX   = DIV_W'((1 << AMP_IN_W) - 1);
    localparam logic [DIV_W-1:0] AMP_POS_MAX  = DIV_W'((1 << (AMP_W - 1)) - 1);
    localparam logic [DIV_W-1:0] AMP_NEG_MAG  = DIV_W'(1 << (AMP_W - 1));
    localparam logic [DIV_W-1:0] POW_POS_MAX  = DIV_W'((1 << (POW_W - 1)) - 1);
    localparam logic [DIV_W-1:0] POW_NEG_MAG  = DIV_W'(1 << (POW_W - 1));

    localparam int PADDR_W    = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_VOLTAGE_GAIN = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_CURRENT_GAIN = REG_IDX_W'(1);

    localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RST = GAIN_W'(844800);
    localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST = GAIN_W'(1320000);

    localparam int NUM_CH = 5;

    typedef enum logic [2:0] {
        CH_VIN         = 3'd0,
        CH_SENSE_IN    = 3'd1,
        CH_VOUT        = 3'd2,
        CH_SENSE_OUT   = 3'd3,
        CH_SENSE_WHEEL = 3'd4
    } ch_t;

    typedef struct packed {
        logic [GAIN_W-1:0] voltage;
        logic [GAIN_W-1:0] current;
    } apm_gain_t;

endpackage

// ===== design/averaged_power_monitor.sv =====
// Channel   Handshake            Carries
// config    psel/penable/pready  voltage_gain at 0x0, current_gain at 0x4
// s_        s_valid/s_ready      six 12-bit converter samples
// m_        m_valid/m_ready      averages in mV and mA, powers in mW
//
// A sample set is taken only in idle; the input is ready again in the cycle
// after the result load, so one set is worked through before the next.
// Twelve divisions (five leak, five scale, two power) take turns on the
// shared divider; 18x22 multiplier steps come before each scale and power one.
// Reset clears the five running sums and restores the default gains.
// A result waits in the output register while the next sample set is taken.
module averaged_power_monitor
    import apm_pkg::*;
#(
    parameter int WINDOW_LEN = 4,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_raw_vin,
    input  logic [SAMPLE_W-1:0]   s_raw_vout,
    input  logic [SAMPLE_W-1:0]   s_raw_sense_in,
    input  logic [SAMPLE_W-1:0]   s_raw_sense_out,
    input  logic [SAMPLE_W-1:0]   s_raw_shunt_ref,
    input  logic [SAMPLE_W-1:0]   s_raw_sense_wheel,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VOLT_W-1:0]     m_volt_in_mv,
    output logic [VOLT_W-1:0]     m_volt_out_mv,
    output logic [AMP_IN_W-1:0]   m_amp_in_ma,
    output logic signed [AMP_W-1:0] m_amp_out_ma,
    output logic signed [AMP_W-1:0] m_amp_wheel_ma,
    output logic signed [POW_W-1:0] m_power_out_mw,
    output logic signed [POW_W-1:0] m_power_wheel_mw,
    output logic [POW_W-1:0]      m_power_total_mw
);

    localparam int SCALE_SHIFT = FRAC_BITS + GAIN_FRAC;
    localparam logic [SUM_W-1:0] SCALE_HALF = SUM_W'(WINDOW_LEN) << (SCALE_SHIFT - 1);
    localparam logic [DEN_W-1:0] WIN_DEN    = DEN_W'(WINDOW_LEN);

    typedef enum logic [11:0] {
        ST_IDLE       = 12'b0000_0000_0001,
        ST_LEAK_GO    = 12'b0000_0000_0010,
        ST_LEAK_WAIT  = 12'b0000_0000_0100,
        ST_MUL_HI     = 12'b0000_0000_1000,
        ST_MUL_LO     = 12'b0000_0001_0000,
        ST_SCALE_ADD  = 12'b0000_0010_0000,
        ST_SCALE_GO   = 12'b0000_0100_0000,
        ST_SCALE_WAIT = 12'b0000_1000_0000,
        ST_POW_MUL    = 12'b0001_0000_0000,
        ST_POW_GO     = 12'b0010_0000_0000,
        ST_POW_WAIT   = 12'b0100_0000_0000,
        ST_FINISH     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    ch_t    ch_reg;
    logic   pow_sel_reg;
    logic   m_valid_reg;

    logic [ACC_W-1:0] acc_reg [NUM_CH];

    logic [SAMPLE_W-1:0] vin_s_reg, vout_s_reg, sin_s_reg;
    logic [SAMPLE_W-1:0] sout_s_reg, sref_s_reg, swh_s_reg;

    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_reg;

    logic [VOLT_W-1:0]   vin_mv_reg, vout_mv_reg;
    logic [AMP_IN_W-1:0] ain_reg;
    logic [AMP_W-1:0]    aout_reg, awh_reg;
    logic [POW_W-1:0]    pout_reg, pwh_reg;

    logic [VOLT_W-1:0]   m_vin_reg, m_vout_reg;
    logic [AMP_IN_W-1:0] m_ain_reg;
    logic [AMP_W-1:0]    m_aout_reg, m_awh_reg;
    logic [POW_W-1:0]    m_pout_reg, m_pwh_reg, m_ptot_reg;

    apm_gain_t gains;

    logic                 in_xfer;
    logic                 out_load;
    logic                 last_ch;
    logic [ACC_W-1:0]     acc_sel;
    logic                 acc_neg;
    logic [ACC_W-1:0]     mag_w;
    logic signed [SAMPLE_W:0] x_w;
    logic [ACC_W-1:0]     xs_w;
    logic [ACC_W-1:0]     acc_leak_w;
    logic [GAIN_W-1:0]    gain_w;
    logic [AMP_W-1:0]     amp_sel_w;
    logic [AMP_W-1:0]     amp_mag_w;
    logic [VOLT_W-1:0]    volt_sel_w;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic                 sign_w;
    logic [DIV_W-1:0]     neg_q_w;
    logic [VOLT_W-1:0]    sat_volt_w;
    logic [AMP_IN_W-1:0]  sat_amp_in_w;
    logic [AMP_W-1:0]     sat_amp_w;
    logic [POW_W-1:0]     sat_pow_w;
    logic signed [POW_W:0] tot_w;
    logic [POW_W-1:0]     tot_clamp_w;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DEN_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [DEN_W-1:0] div_rem;

    apm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    apm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid & s_ready;
    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    assign last_ch  = (ch_reg == CH_SENSE_WHEEL);

    assign acc_sel = acc_reg[ch_reg];
    assign acc_neg = acc_sel[ACC_W-1];
    assign mag_w   = acc_neg ? (ACC_W'(0) - acc_sel) : acc_sel;

    always_comb begin
        case (ch_reg)
            CH_VIN:         x_w = $signed({1'b0, vin_s_reg});
            CH_SENSE_IN:    x_w = $signed({1'b0, sin_s_reg});
            CH_VOUT:        x_w = $signed({1'b0, vout_s_reg});
            CH_SENSE_OUT:   x_w = $signed({1'b0, sout_s_reg}) - $signed({1'b0, sref_s_reg});
            CH_SENSE_WHEEL: x_w = $signed({1'b0, swh_s_reg}) - $signed({1'b0, sref_s_reg});
            default:        x_w = '0;
        endcase
    end

    assign xs_w = ACC_W'(x_w) << FRAC_BITS;

    // The leak term rounds toward minus infinity, so a negative sum with a
    // nonzero remainder takes one more off its quotient.
    assign acc_leak_w = acc_sel + xs_w
                      + (acc_neg ? (div_quo + ACC_W'(div_rem != '0))
                                 : (ACC_W'(0) - div_quo));

    assign gain_w = ((ch_reg == CH_VIN) || (ch_reg == CH_VOUT)) ? gains.voltage
                                                                 : gains.current;

    assign amp_sel_w  = pow_sel_reg ? awh_reg : aout_reg;
    assign amp_mag_w  = amp_sel_w[AMP_W-1] ? (AMP_W'(0) - amp_sel_w) : amp_sel_w;
    assign volt_sel_w = pow_sel_reg ? vin_mv_reg : vout_mv_reg;

    always_comb begin
        case (state_reg)
            ST_MUL_HI: begin
                mul_a = MUL_A_W'(mag_w[2*SPLIT-1:SPLIT]);
                mul_b = gain_w;
            end
            ST_MUL_LO: begin
                mul_a = MUL_A_W'(mag_w[SPLIT-1:0]);
                mul_b = gain_w;
            end
            ST_POW_MUL: begin
                mul_a = amp_mag_w;
                mul_b = MUL_B_W'(volt_sel_w);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start = (state_reg == ST_LEAK_GO) || (state_reg == ST_SCALE_GO)
                 || (state_reg == ST_POW_GO);
        case (state_reg)
            ST_LEAK_GO:  div_dividend = mag_w;
            ST_SCALE_GO: div_dividend = DIV_W'(sum_reg >> SCALE_SHIFT);
            ST_POW_GO:   div_dividend = DIV_W'(prod_reg) + POW_HALF;
            default:     div_dividend = '0;
        endcase
        div_divisor = (state_reg == ST_POW_GO) ? POW_DEN : WIN_DEN;
    end

    assign sign_w  = (state_reg == ST_POW_WAIT) ? amp_sel_w[AMP_W-1] : acc_neg;
    assign neg_q_w = DIV_W'(0) - div_quo;

    always_comb begin
        if (sign_w && (div_quo != '0)) begin
            sat_volt_w   = '0;
            sat_amp_in_w = '0;
        end else begin
            sat_volt_w   = (div_quo > VOLT_MAX) ? VOLT_W'(VOLT_MAX) : div_quo[VOLT_W-1:0];
            sat_amp_in_w = (div_quo > AMP_IN_MAX) ? AMP_IN_W'(AMP_IN_MAX)
                                                  : div_quo[AMP_IN_W-1:0];
        end
        if (sign_w) begin
            sat_amp_w = (div_quo > AMP_NEG_MAG) ? AMP_W'(AMP_NEG_MAG) : neg_q_w[AMP_W-1:0];
            sat_pow_w = (div_quo > POW_NEG_MAG) ? POW_W'(POW_NEG_MAG) : neg_q_w[POW_W-1:0];
        end else begin
            sat_amp_w = (div_quo > AMP_POS_MAX) ? AMP_W'(AMP_POS_MAX) : div_quo[AMP_W-1:0];
            sat_pow_w = (div_quo > POW_POS_MAX) ? POW_W'(POW_POS_MAX) : div_quo[POW_W-1:0];
        end
    end

    assign tot_w = $signed({pout_reg[POW_W-1], pout_reg})
                 + $signed({pwh_reg[POW_W-1], pwh_reg});
    assign tot_clamp_w = (tot_w[POW_W] || (tot_w == '0)) ? '0 : tot_w[POW_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (s_valid) state_next = ST_LEAK_GO;
            ST_LEAK_GO:    state_next = ST_LEAK_WAIT;
            ST_LEAK_WAIT:  if (div_done) state_next = last_ch ? ST_MUL_HI : ST_LEAK_GO;
            ST_MUL_HI:     state_next = ST_MUL_LO;
            ST_MUL_LO:     state_next = ST_SCALE_ADD;
            ST_SCALE_ADD:  state_next = ST_SCALE_GO;
            ST_SCALE_GO:   state_next = ST_SCALE_WAIT;
            ST_SCALE_WAIT: if (div_done) state_next = last_ch ? ST_POW_MUL : ST_MUL_HI;
            ST_POW_MUL:    state_next = ST_POW_GO;
            ST_POW_GO:     state_next = ST_POW_WAIT;
            ST_POW_WAIT:   if (div_done) state_next = pow_sel_reg ? ST_FINISH : ST_POW_MUL;
            ST_FINISH:     if (out_load) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= CH_VIN;
            pow_sel_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_CH; k++) begin
                acc_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (in_xfer) begin
                ch_reg      <= CH_VIN;
                pow_sel_reg <= 1'b0;
            end
            if (div_done && ((state_reg == ST_LEAK_WAIT) || (state_reg == ST_SCALE_WAIT))) begin
                ch_reg <= last_ch ? CH_VIN : ch_t'(ch_reg + 3'd1);
            end
            if (div_done && (state_reg == ST_LEAK_WAIT)) begin
                acc_reg[ch_reg] <= acc_leak_w;
            end
            if (div_done && (state_reg == ST_POW_WAIT)) begin
                pow_sel_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (in_xfer) begin
            vin_s_reg  <= s_raw_vin;
            vout_s_reg <= s_raw_vout;
            sin_s_reg  <= s_raw_sense_in;
            sout_s_reg <= s_raw_sense_out;
            sref_s_reg <= s_raw_shunt_ref;
            swh_s_reg  <= s_raw_sense_wheel;
        end
        if (state_reg == ST_MUL_LO) begin
            sum_reg <= (SUM_W'(prod_reg) << SPLIT) + SCALE_HALF;
        end else if (state_reg == ST_SCALE_ADD) begin
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        end
        if (div_done && (state_reg == ST_SCALE_WAIT)) begin
            case (ch_reg)
                CH_VIN:         vin_mv_reg  <= sat_volt_w;
                CH_SENSE_IN:    ain_reg     <= sat_amp_in_w;
                CH_VOUT:        vout_mv_reg <= sat_volt_w;
                CH_SENSE_OUT:   aout_reg    <= sat_amp_w;
                CH_SENSE_WHEEL: awh_reg     <= sat_amp_w;
                default: ;
            endcase
        end
        if (div_done && (state_reg == ST_POW_WAIT)) begin
            if (pow_sel_reg) begin
                pwh_reg <= sat_pow_w;
            end else begin
                pout_reg <= sat_pow_w;
            end
        end
        if (out_load) begin
            m_vin_reg  <= vin_mv_reg;
            m_vout_reg <= vout_mv_reg;
            m_ain_reg  <= ain_reg;
            m_aout_reg <= aout_reg;
            m_awh_reg  <= awh_reg;
            m_pout_reg <= pout_reg;
            m_pwh_reg  <= pwh_reg;
            m_ptot_reg <= tot_clamp_w;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_volt_in_mv     = m_vin_reg;
    assign m_volt_out_mv    = m_vout_reg;
    assign m_amp_in_ma      = m_ain_reg;
    assign m_amp_out_ma     = $signed(m_aout_reg);
    assign m_amp_wheel_ma   = $signed(m_awh_reg);
    assign m_power_out_mw   = $signed(m_pout_reg);
    assign m_power_wheel_mw = $signed(m_pwh_reg);
    assign m_power_total_mw = m_ptot_reg;

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_LEAK_WAIT) || (state_reg == ST_SCALE_WAIT)
                  || (state_reg == ST_POW_WAIT))
        else $error("divider finished outside a wait state");

    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still ready after a transfer");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result valid without a finished item");

    a_volt_sums_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        !acc_reg[CH_VIN][ACC_W-1] && !acc_reg[CH_VOUT][ACC_W-1]
        && !acc_reg[CH_SENSE_IN][ACC_W-1])
        else $error("running sum of an unsigned channel went negative");

endmodule

// ===== design/apm_cfg.sv =====
module apm_cfg
    import apm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output apm_gain_t             gains
);

    apm_gain_t              gains_reg;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign gains   = gains_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.voltage <= VOLTAGE_GAIN_RST;
            gains_reg.current <= CURRENT_GAIN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_VOLTAGE_GAIN: gains_reg.voltage <= pwdata[GAIN_W-1:0];
                REG_CURRENT_GAIN: gains_reg.current <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_VOLTAGE_GAIN: prdata = APB_DATA_W'(gains_reg.voltage);
            REG_CURRENT_GAIN: prdata = APB_DATA_W'(gains_reg.current);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== design/apm_div.sv =====
module apm_div
    import apm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic [DEN_W-1:0] remainder
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     num_reg;
    logic [DIV_W-1:0]     num_next;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     rem_next;
    logic [DEN_W-1:0]     den_reg;

    // Restoring division, DIV_STEP quotient bits per cycle.
    always_comb begin
        logic [DEN_W:0] trial;
        num_next = num_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int j = 0; j < DIV_STEP; j++) begin
            trial    = {rem_next, num_next[DIV_W-1]};
            num_next = {num_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_next[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = DEN_W'(trial);
                quo_next = {quo_next[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_ITER - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            quo_reg <= '0;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            num_reg <= num_next;
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
